FILE: rtl/core/bcfd_pkg.sv
`timescale 1ns / 1ps

package bcfd_pkg;

    // standard identifiers decoded by the block
    localparam logic [28:0] ID_VOLTAGES = 29'h1B0;
    localparam logic [28:0] ID_CHARGE   = 29'h1B1;
    localparam logic [28:0] ID_CURRENT  = 29'h2BA;

    // charge values above full scale are dropped
    localparam logic [15:0] PERCENT_FULL = 16'd10000;

    // watts to units of 0.1 mW per mV * dA
    localparam logic signed [34:0] PWR_SCALE = 35'sd10000;

    // configuration reset values
    localparam logic [15:0] PACK_MIN_RST   = 16'd40000;
    localparam logic [15:0] PACK_MAX_RST   = 16'd65000;
    localparam logic [15:0] CELL_FLOOR_RST = 16'd2000;
    localparam logic [15:0] CELL_CEIL_RST  = 16'd5000;
    localparam logic [31:0] STALE_RST      = 32'd10000;
    localparam logic signed [34:0] LIM_LO_RST = -35'sd300000000;
    localparam logic signed [34:0] LIM_HI_RST = 35'sd200000000;
    localparam logic [14:0] FLOW_THR_RST   = 15'd20;

    typedef enum logic [1:0] {
        KIND_IGNORED  = 2'd0,
        KIND_VOLTAGES = 2'd1,
        KIND_CHARGE   = 2'd2,
        KIND_CURRENT  = 2'd3
    } frame_kind_t;

    typedef enum logic [2:0] {
        CFG_PACK_MIN   = 3'd0,
        CFG_PACK_MAX   = 3'd1,
        CFG_CELL_FLOOR = 3'd2,
        CFG_CELL_CEIL  = 3'd3,
        CFG_STALE      = 3'd4,
        CFG_POWER_LOW  = 3'd5,
        CFG_POWER_HIGH = 3'd6,
        CFG_FLOW_THR   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        is_extended;
        logic [3:0]  length_code;
        logic [28:0] frame_id;
        logic [63:0] payload;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic [6:0]         valid_flags;
        logic [15:0]        pack_voltage_mv;
        logic [15:0]        cell_min_mv;
        logic [15:0]        cell_max_mv;
        logic [13:0]        soc_hundredths;
        logic [13:0]        soh_hundredths;
        logic signed [15:0] current_da;
        logic signed [31:0] power_fine;
        logic [15:0]        rejected_pack;
        logic [15:0]        rejected_cells;
        logic [15:0]        rejected_current;
    } out_item_t;

    // saturating event counter step
    function automatic logic [15:0] sat_inc(input logic [15:0] count);
        sat_inc = (count == 16'hFFFF) ? count : count + 16'd1;
    endfunction

endpackage

FILE: rtl/core/battery_can_frame_decoder_unit.sv
`timescale 1ns / 1ps

// Battery CAN frame decoder. Each accepted frame passes through the input
// register and gives exactly one result in the result register: the frame
// kind plus a snapshot of all stored battery values, valid flags and reject
// counters after that frame. Standard frames with a length code of 8 or more
// and identifier 0x1B0 (voltages), 0x1B1 (charge state) or 0x2BA (current)
// update the store; everything else reports kind 0.
// A frame is taken every cycle while the result side is not stalled: the
// frame sits in the input register, while one combinational pass (a single
// 16x16 multiply plus the window compares) updates the store and loads the
// result register. Stalls on the result side back up through the input
// register. Configuration writes are taken at any time (ready is always
// high) and should be made with no frame in flight.
module battery_can_frame_decoder_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bcfd_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bcfd_pkg::out_item_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import bcfd_pkg::*;

    // configuration registers
    logic [15:0]        pack_min_reg, pack_max_reg, cell_floor_reg, cell_ceil_reg;
    logic [31:0]        stale_reg;
    logic signed [34:0] lim_lo_reg, lim_hi_reg;
    logic [14:0]        flow_thr_reg;

    // stored decode state
    logic               pack_ok_reg, cells_ok_reg, soc_ok_reg, soh_ok_reg, cur_ok_reg;
    logic               regen_reg, discharge_reg;
    logic [15:0]        pack_mv_reg, cell_low_reg, cell_high_reg;
    logic [31:0]        pack_stamp_reg;
    logic [13:0]        soc_reg, soh_reg;
    logic [15:0]        cur_reg;
    logic [31:0]        power_reg;
    logic [15:0]        pack_rej_reg, cell_rej_reg, cur_rej_reg;

    logic               pack_ok_next, cells_ok_next, soc_ok_next, soh_ok_next;
    logic               cur_ok_next, regen_next, discharge_next;
    logic [15:0]        pack_mv_next, cell_low_next, cell_high_next;
    logic [31:0]        pack_stamp_next;
    logic [13:0]        soc_next, soh_next;
    logic [15:0]        cur_next;
    logic [31:0]        power_next;
    logic [15:0]        pack_rej_next, cell_rej_next, cur_rej_next;

    // pipeline registers
    logic               in_valid_reg;
    in_item_t           in_data_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;

    logic               advance;
    logic               frame_ok;
    frame_kind_t        kind;
    logic [15:0]        volt_pack, volt_lo, volt_hi, chg_soc, chg_soh, cur_raw;
    logic               pack_in_win, cells_in_win, fresh;
    logic [31:0]        age;
    logic signed [32:0] power;
    logic signed [34:0] power_ext;
    logic               power_in_win;
    logic signed [16:0] cur_s, thr_s;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_min_reg   <= PACK_MIN_RST;
            pack_max_reg   <= PACK_MAX_RST;
            cell_floor_reg <= CELL_FLOOR_RST;
            cell_ceil_reg  <= CELL_CEIL_RST;
            stale_reg      <= STALE_RST;
            lim_lo_reg     <= LIM_LO_RST;
            lim_hi_reg     <= LIM_HI_RST;
            flow_thr_reg   <= FLOW_THR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PACK_MIN:   pack_min_reg   <= cfg_data[15:0];
                CFG_PACK_MAX:   pack_max_reg   <= cfg_data[15:0];
                CFG_CELL_FLOOR: cell_floor_reg <= cfg_data[15:0];
                CFG_CELL_CEIL:  cell_ceil_reg  <= cfg_data[15:0];
                CFG_STALE:      stale_reg      <= cfg_data;
                // power limits kept pre-scaled to 0.1 mW
                CFG_POWER_LOW:  lim_lo_reg <= 35'($signed(cfg_data[20:0])) * PWR_SCALE;
                CFG_POWER_HIGH: lim_hi_reg <= 35'($signed({1'b0, cfg_data[19:0]}))
                                              * PWR_SCALE;
                CFG_FLOW_THR:   flow_thr_reg   <= cfg_data[14:0];
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
    end

    // field extraction and classification
    assign frame_ok  = !in_data_reg.is_extended && in_data_reg.length_code[3];
    assign volt_pack = in_data_reg.payload[47:32];
    assign volt_lo   = in_data_reg.payload[31:16];
    assign volt_hi   = in_data_reg.payload[15:0];
    assign chg_soc   = in_data_reg.payload[63:48];
    assign chg_soh   = in_data_reg.payload[47:32];
    assign cur_raw   = in_data_reg.payload[63:48];

    always_comb
    begin
        kind = KIND_IGNORED;
        if (frame_ok)
        begin
            if (in_data_reg.frame_id == ID_VOLTAGES)
                kind = KIND_VOLTAGES;
            else if (in_data_reg.frame_id == ID_CHARGE)
                kind = KIND_CHARGE;
            else if (in_data_reg.frame_id == ID_CURRENT)
                kind = KIND_CURRENT;
        end
    end

    // plausibility checks
    assign pack_in_win  = (volt_pack >= pack_min_reg) && (volt_pack <= pack_max_reg);
    assign cells_in_win = (volt_lo >= cell_floor_reg) && (volt_hi <= cell_ceil_reg)
                          && (volt_lo <= volt_hi);
    assign age          = in_data_reg.now_ms - pack_stamp_reg;
    assign fresh        = pack_ok_reg && (age <= stale_reg);
    assign power        = 33'($signed(cur_raw)) * 33'($signed({1'b0, pack_mv_reg}));
    assign power_ext    = 35'(power);
    assign power_in_win = !(power_ext < lim_lo_reg) && !(power_ext > lim_hi_reg);
    assign cur_s        = 17'($signed(cur_raw));
    assign thr_s        = $signed({2'b00, flow_thr_reg});

    // state update
    always_comb
    begin
        pack_ok_next    = pack_ok_reg;
        pack_mv_next    = pack_mv_reg;
        pack_stamp_next = pack_stamp_reg;
        cells_ok_next   = cells_ok_reg;
        cell_low_next   = cell_low_reg;
        cell_high_next  = cell_high_reg;
        soc_ok_next     = soc_ok_reg;
        soc_next        = soc_reg;
        soh_ok_next     = soh_ok_reg;
        soh_next        = soh_reg;
        cur_ok_next     = cur_ok_reg;
        cur_next        = cur_reg;
        power_next      = power_reg;
        regen_next      = regen_reg;
        discharge_next  = discharge_reg;
        pack_rej_next   = pack_rej_reg;
        cell_rej_next   = cell_rej_reg;
        cur_rej_next    = cur_rej_reg;
        case (kind)
            KIND_VOLTAGES:
            begin
                if (pack_in_win)
                begin
                    pack_ok_next    = 1'b1;
                    pack_mv_next    = volt_pack;
                    pack_stamp_next = in_data_reg.now_ms;
                end
                else
                    pack_rej_next = sat_inc(pack_rej_reg);
                if (cells_in_win)
                begin
                    cells_ok_next  = 1'b1;
                    cell_low_next  = volt_lo;
                    cell_high_next = volt_hi;
                end
                else
                    cell_rej_next = sat_inc(cell_rej_reg);
            end
            KIND_CHARGE:
            begin
                if (chg_soc <= PERCENT_FULL)
                begin
                    soc_ok_next = 1'b1;
                    soc_next    = chg_soc[13:0];
                end
                if (chg_soh <= PERCENT_FULL)
                begin
                    soh_ok_next = 1'b1;
                    soh_next    = chg_soh[13:0];
                end
            end
            KIND_CURRENT:
            begin
                // no or stale pack voltage leaves everything as is
                if (fresh)
                begin
                    if (power_in_win)
                    begin
                        cur_ok_next    = 1'b1;
                        cur_next       = cur_raw;
                        power_next     = power[31:0];
                        regen_next     = cur_s > thr_s;
                        discharge_next = cur_s < -thr_s;
                    end
                    else
                        cur_rej_next = sat_inc(cur_rej_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pack_ok_reg    <= 1'b0;
            pack_mv_reg    <= '0;
            pack_stamp_reg <= '0;
            cells_ok_reg   <= 1'b0;
            cell_low_reg   <= '0;
            cell_high_reg  <= '0;
            soc_ok_reg     <= 1'b0;
            soc_reg        <= '0;
            soh_ok_reg     <= 1'b0;
            soh_reg        <= '0;
            cur_ok_reg     <= 1'b0;
            cur_reg        <= '0;
            power_reg      <= '0;
            regen_reg      <= 1'b0;
            discharge_reg  <= 1'b0;
            pack_rej_reg   <= '0;
            cell_rej_reg   <= '0;
            cur_rej_reg    <= '0;
        end
        else if (advance)
        begin
            pack_ok_reg    <= pack_ok_next;
            pack_mv_reg    <= pack_mv_next;
            pack_stamp_reg <= pack_stamp_next;
            cells_ok_reg   <= cells_ok_next;
            cell_low_reg   <= cell_low_next;
            cell_high_reg  <= cell_high_next;
            soc_ok_reg     <= soc_ok_next;
            soc_reg        <= soc_next;
            soh_ok_reg     <= soh_ok_next;
            soh_reg        <= soh_next;
            cur_ok_reg     <= cur_ok_next;
            cur_reg        <= cur_next;
            power_reg      <= power_next;
            regen_reg      <= regen_next;
            discharge_reg  <= discharge_next;
            pack_rej_reg   <= pack_rej_next;
            cell_rej_reg   <= cell_rej_next;
            cur_rej_reg    <= cur_rej_next;
        end
    end

    // result assembly from the updated state
    always_comb
    begin
        out_data_next.frame_kind       = kind;
        out_data_next.valid_flags      = {discharge_next, regen_next, cur_ok_next,
                                          soh_ok_next, soc_ok_next, cells_ok_next,
                                          pack_ok_next};
        out_data_next.pack_voltage_mv  = pack_mv_next;
        out_data_next.cell_min_mv      = cell_low_next;
        out_data_next.cell_max_mv      = cell_high_next;
        out_data_next.soc_hundredths   = soc_next;
        out_data_next.soh_hundredths   = soh_next;
        out_data_next.current_da       = $signed(cur_next);
        out_data_next.power_fine       = $signed(power_next);
        out_data_next.rejected_pack    = pack_rej_next;
        out_data_next.rejected_cells   = cell_rej_next;
        out_data_next.rejected_current = cur_rej_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/core/bcfd_checker.sv
`timescale 1ns / 1ps

module bcfd_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  bcfd_pkg::out_item_t out_data
);
    import bcfd_pkg::*;

    localparam int OUT_W = $bits(out_item_t);

    out_item_t last_reg;
    logic      out_xfer;

    assign out_xfer = out_valid && out_ready;

    // last transferred result, reset matches the cleared store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else if (out_xfer)
            last_reg <= out_data;
    end

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input side only blocks behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // an ignored frame leaves the whole store unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && out_data.frame_kind == KIND_IGNORED
        |-> out_data[OUT_W-3:0] == last_reg[OUT_W-3:0])
        else $error("ignored frame changed stored state");

    // regen and discharge never set together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(out_data.valid_flags[6:5]))
        else $error("regen and discharge both set");

    // reject counters never go down
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> out_data.rejected_pack >= last_reg.rejected_pack
                  && out_data.rejected_cells >= last_reg.rejected_cells
                  && out_data.rejected_current >= last_reg.rejected_current)
        else $error("reject counter decreased");

endmodule

bind battery_can_frame_decoder_unit bcfd_checker u_bcfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
